// File: rtl/core/swerm_pkg.sv
// Shared types and constants for the sliding window event rate monitor.
package swerm_pkg;
  localparam int unsigned RingDepthDefault = 16384;
  localparam int unsigned ThrW = 15;
  localparam int unsigned WinW = 34;
  localparam int unsigned StampW = 64;
  localparam int unsigned SrcW = 32;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 34;
  localparam logic [CfgAddrW-1:0] CFG_LOW_THRESHOLD = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_WINDOW_LENGTH = 1'b1;
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic [ThrW-1:0] LowThresholdReset = 15'd500;
  localparam logic [WinW-1:0] WindowLengthReset = 34'd50000000;

  typedef struct packed {
    logic             cmd;
    logic [SrcW-1:0]  source_id;
    logic             high_flag;
    logic [StampW-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              high_alarm;
    logic              low_alarm;
    logic [ThrW-1:0]   window_count;
    logic              deadline_valid;
    logic [StampW-1:0] next_deadline;
  } out_item_t;

  // Operations the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture item, compute lock/match
    OP_RD_HEAD,   // issue read of ring head
    OP_EVICT,     // test head entry, pop if expired
    OP_PUSH,      // write stamp, update flags
    OP_PLAN_PRE,  // evaluate first-window condition
    OP_RD_CRIT,   // issue read of critical entry
    OP_SET_DL,    // deadline from critical entry
    OP_CHECK,     // low bound check on tick
    OP_OUT        // load result register
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   clr_deadline;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic matched;      // event from watched source
    logic tick_due;     // tick at or past the deadline
    logic ring_empty;
    logic expired;      // head entry older than the window
    logic plan_none;    // no source lock or no first stamp
    logic in_first;     // still inside the first window
    logic below_thr;
  } dp_sts_t;
endpackage

// File: rtl/core/swerm_if.sv
// Valid/ready channel carrying one payload.
interface swerm_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/swerm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module swerm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/swerm_datapath.sv
// Datapath: ring memory, pointers, flags, deadline and result register.
module swerm_datapath #(
  parameter int unsigned RingDepth = swerm_pkg::RingDepthDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  swerm_pkg::in_item_t       in_item,
  input  logic [swerm_pkg::ThrW-1:0] low_threshold,
  input  logic [swerm_pkg::WinW-1:0] window_length,
  input  swerm_pkg::dp_cmd_t        cmd,
  output swerm_pkg::dp_sts_t        sts,
  output swerm_pkg::out_item_t      result
);
  import swerm_pkg::*;
  localparam int unsigned AW = $clog2(RingDepth);
  localparam int unsigned CW = $clog2(RingDepth + 1);

  in_item_t          item_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     count_r;
  logic [SrcW-1:0]   watched_r;
  logic [StampW-1:0] first_r;
  logic              high_rep_r, low_rep_r, acc_r, hi_r, lo_r;
  logic [StampW-1:0] deadline_r;
  logic [StampW-1:0] head_stamp;
  logic [StampW-1:0] win64;
  logic [AW-1:0]     raddr;
  logic              ram_we;
  logic [AW-1:0]     waddr;
  logic [CW-1:0]     pos;
  logic [CW:0]       sum_wide;
  logic [CW-1:0]     thr_c;
  logic [ThrW:0]     thr_w;
  logic [CW:0]       cnt_w;
  logic              full;
  out_item_t         result_r;

  assign win64 = {{(StampW-WinW){1'b0}}, window_length};
  assign full = (count_r == CW'(RingDepth));

  // Compare counts at a common width.
  assign thr_w = {1'b0, low_threshold};
  assign cnt_w = {1'b0, count_r};
  assign sts.below_thr = (CW + 1 > ThrW + 1) ? (cnt_w < (CW+1)'(thr_w))
                                             : ((ThrW+1)'(cnt_w) < thr_w);
  assign thr_c = CW'(low_threshold);
  assign pos = count_r - thr_c;

  always_comb begin
    sum_wide = {1'b0, CW'(head_r)} + {1'b0, pos};
    if (sum_wide >= (CW+1)'(RingDepth)) sum_wide = sum_wide - (CW+1)'(RingDepth);
    raddr = head_r;
    if (cmd.op == OP_RD_CRIT) raddr = sum_wide[AW-1:0];
  end

  logic [CW:0] wsum;
  always_comb begin
    wsum = {1'b0, CW'(head_r)} + {1'b0, count_r};
    if (wsum >= (CW+1)'(RingDepth)) wsum = wsum - (CW+1)'(RingDepth);
    waddr = wsum[AW-1:0];
  end

  // A full ring writes over the oldest entry, which sits at the head.
  assign ram_we = (cmd.op == OP_PUSH);

  swerm_ram #(.Width(StampW), .Depth(RingDepth)) u_ram (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(item_r.stamp),
    .raddr(raddr), .rdata(head_stamp)
  );

  assign sts.is_tick = item_r.cmd == CMD_TICK;
  assign sts.matched = item_r.source_id == watched_r;
  assign sts.tick_due = (deadline_r != '0) && (item_r.stamp >= deadline_r);
  assign sts.ring_empty = count_r == '0;
  assign sts.expired = (item_r.stamp - head_stamp) > win64;
  assign sts.plan_none = (watched_r == '0) || (first_r == '0);
  assign sts.in_first = (item_r.stamp - first_r) < win64;
  assign result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0; count_r <= '0; watched_r <= '0; first_r <= '0;
      high_rep_r <= 1'b0; low_rep_r <= 1'b0; deadline_r <= '0;
      acc_r <= 1'b0; hi_r <= 1'b0; lo_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          item_r <= in_item;
          acc_r <= 1'b0; hi_r <= 1'b0; lo_r <= 1'b0;
          if (in_item.cmd == CMD_EVENT && watched_r == '0) begin
            watched_r <= in_item.source_id;
            first_r <= in_item.stamp;
          end
        end
        OP_EVICT: begin
          if (!sts.ring_empty && sts.expired) begin
            head_r <= (head_r == AW'(RingDepth - 1)) ? '0 : head_r + 1'b1;
            count_r <= count_r - 1'b1;
          end
        end
        OP_PUSH: begin
          acc_r <= 1'b1;
          // Ring full: overwrite oldest by advancing the head.
          if (full) begin
            head_r <= (head_r == AW'(RingDepth - 1)) ? '0 : head_r + 1'b1;
          end else begin
            count_r <= count_r + 1'b1;
          end
          if (item_r.high_flag) begin
            if (!high_rep_r) begin
              hi_r <= 1'b1; high_rep_r <= 1'b1;
            end
          end else begin
            high_rep_r <= 1'b0;
          end
        end
        OP_PLAN_PRE: begin
          if (acc_r && !sts.below_thr) low_rep_r <= 1'b0;
          if (sts.plan_none) deadline_r <= '0;
          else if (sts.in_first) deadline_r <= first_r + win64 + 64'd1;
        end
        OP_SET_DL: begin
          if (cmd.clr_deadline) deadline_r <= '0;
          else deadline_r <= head_stamp + win64 + 64'd1;
        end
        OP_CHECK: begin
          if (!sts.plan_none && !sts.in_first) begin
            if (sts.below_thr) begin
              if (!low_rep_r) begin
                lo_r <= 1'b1; low_rep_r <= 1'b1;
              end
            end else begin
              low_rep_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      result_r.accepted <= acc_r;
      result_r.high_alarm <= hi_r;
      result_r.low_alarm <= lo_r;
      result_r.window_count <= ThrW'(count_r);
      result_r.deadline_valid <= deadline_r != '0;
      result_r.next_deadline <= deadline_r;
    end
  end
endmodule

// File: rtl/core/swerm_ctrl.sv
// Controller: sequences eviction, push, low check and deadline planning.
module swerm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  swerm_pkg::dp_sts_t sts,
  output swerm_pkg::dp_cmd_t cmd
);
  import swerm_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EV_RD, S_EV_TEST, S_PUSH, S_CHECK,
    S_PLAN, S_PL_RD, S_PL_TEST, S_CRIT_RD, S_CRIT_WAIT, S_CRIT_SET, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;
  logic   planning_r, planning_nxt; // eviction belongs to planning pass

  // Accept whenever idle; a waiting result stays in its own register.
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = valid_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    planning_nxt = planning_r;
    cmd = '{op: OP_NONE, clr_deadline: 1'b0};
    if (valid_r && out_ready) valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        planning_nxt = 1'b0;
        if (sts.is_tick) state_nxt = sts.tick_due ? S_EV_RD : S_OUT;
        else state_nxt = sts.matched ? S_EV_RD : S_OUT;
      end
      S_EV_RD: state_nxt = S_EV_TEST;
      S_EV_TEST: begin
        if (!sts.ring_empty && sts.expired) begin
          cmd.op = OP_EVICT;
          state_nxt = S_EV_RD;
        end else if (planning_r) state_nxt = S_CRIT_RD;
        else if (sts.is_tick) state_nxt = S_CHECK;
        else state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.op = OP_PUSH;
        state_nxt = S_PLAN;
      end
      S_CHECK: begin
        cmd.op = OP_CHECK;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        cmd.op = OP_PLAN_PRE;
        if (sts.plan_none || sts.in_first) state_nxt = S_OUT;
        else begin
          planning_nxt = 1'b1;
          state_nxt = S_EV_RD;
        end
      end
      S_CRIT_RD: begin
        if (sts.below_thr) begin
          cmd.op = OP_SET_DL;
          cmd.clr_deadline = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.op = OP_RD_CRIT;
          state_nxt = S_CRIT_WAIT;
        end
      end
      S_CRIT_WAIT: begin
        cmd.op = OP_RD_CRIT;
        state_nxt = S_CRIT_SET;
      end
      S_CRIT_SET: begin
        cmd.op = OP_SET_DL;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!valid_r || out_ready) begin
          cmd.op = OP_OUT;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= 1'b0; planning_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; planning_r <= planning_nxt;
    end
  end
endmodule

// File: rtl/core/sliding_window_event_rate_monitor.sv
// Sliding window event rate monitor: one result per item, one item at a time.
// A watched-source event evicts expired stamps and is pushed; past the first
// window the deadline planning evicts again, then reads the critical entry of
// the ring memory. A tick before its deadline goes straight to its result. The
// ring is a single RAM with registered read; every stamp test is one read and
// one compare, which sets the per-eviction cost. The result sits in an output
// register so the next item can be taken while it waits.
module sliding_window_event_rate_monitor #(
  parameter int unsigned RingDepth = swerm_pkg::RingDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  swerm_if.sink                         in_ch,
  swerm_if.source                       out_ch,
  input  logic                          cfg_we,
  input  logic [swerm_pkg::CfgAddrW-1:0] cfg_index,
  input  logic [swerm_pkg::CfgDataW-1:0] cfg_data
);
  import swerm_pkg::*;
  logic [ThrW-1:0] low_threshold_r;
  logic [WinW-1:0] window_length_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  out_item_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_threshold_r <= LowThresholdReset;
      window_length_r <= WindowLengthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_THRESHOLD: low_threshold_r <= cfg_data[ThrW-1:0];
        CFG_WINDOW_LENGTH: window_length_r <= cfg_data[WinW-1:0];
        default: ;
      endcase
    end
  end

  swerm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  swerm_datapath #(.RingDepth(RingDepth)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_ch.data),
    .low_threshold(low_threshold_r), .window_length(window_length_r),
    .cmd(cmd), .sts(sts), .result(result)
  );

  assign out_ch.data = result;
endmodule

// File: rtl/core/swerm_checker.sv
// Port-level checker for the rate monitor, bound to the top level.
module swerm_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input swerm_pkg::out_item_t  out_data
);
  import swerm_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");
  a_dl_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.deadline_valid == (out_data.next_deadline != '0))
    else $error("deadline flag mismatch");
  a_tick_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.low_alarm)
    else $error("event raised low alarm");
endmodule

bind sliding_window_event_rate_monitor swerm_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

// File: test/tb_sliding_window_event_rate_monitor.sv
// Self-checking testbench for the sliding window event rate monitor.
`timescale 1ns / 100ps

module tb_sliding_window_event_rate_monitor;
  import swerm_pkg::*;

  class rate_scoreboard;
    localparam int unsigned Depth = RingDepthDefault;
    bit [63:0]   stamps [Depth];
    int unsigned head;
    int unsigned count;
    bit [31:0]   watched;
    bit [63:0]   first_t;
    bit [63:0]   deadline;
    bit          high_done;
    bit          low_done;
    int unsigned threshold;
    bit [63:0]   window;
    out_item_t   pending_results[$];
    int unsigned errors;

    function new();
      threshold = LowThresholdReset;
      window    = 64'(WindowLengthReset);
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] v);
      if (idx == CFG_LOW_THRESHOLD) threshold = v[ThrW-1:0];
      else window = 64'(v);
    endfunction

    function void evict(bit [63:0] t);
      while (count > 0 && (t - stamps[head]) > window) begin
        head = (head + 1) % Depth;
        count--;
      end
    endfunction

    function void push_stamp(bit [63:0] t);
      evict(t);
      if (count >= Depth) begin
        head  = (head + 1) % Depth;
        count = Depth - 1;
      end
      stamps[(head + count) % Depth] = t;
      count++;
    endfunction

    function void plan_deadline(bit [63:0] t);
      if (watched == 0 || first_t == 0) begin
        deadline = 0;
      end else if ((t - first_t) < window) begin
        deadline = first_t + window + 64'd1;
      end else begin
        evict(t);
        if (count < threshold) deadline = 0;
        else deadline = stamps[(head + count - threshold) % Depth] + window + 64'd1;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      r = '0;
      if (it.cmd == CMD_EVENT) begin
        if (watched == 0) begin
          watched = it.source_id;
          first_t = it.stamp;
        end
        if (it.source_id == watched) begin
          r.accepted = 1'b1;
          push_stamp(it.stamp);
          if (it.high_flag) begin
            if (!high_done) begin
              r.high_alarm = 1'b1;
              high_done = 1'b1;
            end
          end else begin
            high_done = 1'b0;
          end
          if (count >= threshold) low_done = 1'b0;
          plan_deadline(it.stamp);
        end
      end else if (deadline != 0 && it.stamp >= deadline) begin
        evict(it.stamp);
        if (watched != 0 && first_t != 0 && (it.stamp - first_t) >= window) begin
          if (count < threshold) begin
            if (!low_done) begin
              r.low_alarm = 1'b1;
              low_done = 1'b1;
            end
          end else begin
            low_done = 1'b0;
          end
        end
        plan_deadline(it.stamp);
      end
      r.window_count   = count[ThrW-1:0];
      r.deadline_valid = (deadline != 0);
      r.next_deadline  = deadline;
      pending_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      exp = pending_results.pop_front();
      if (got.accepted !== exp.accepted || got.high_alarm !== exp.high_alarm ||
          got.low_alarm !== exp.low_alarm || got.window_count !== exp.window_count ||
          got.deadline_valid !== exp.deadline_valid ||
          got.next_deadline !== exp.next_deadline) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: acc %b/%b hi %b/%b lo %b/%b cnt %0d/%0d dv %b/%b dl %0d/%0d",
                   exp.accepted, got.accepted, exp.high_alarm, got.high_alarm,
                   exp.low_alarm, got.low_alarm, exp.window_count, got.window_count,
                   exp.deadline_valid, got.deadline_valid,
                   exp.next_deadline, got.next_deadline);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  swerm_if #(.payload_t(in_item_t))  in_ch (clk);
  swerm_if #(.payload_t(out_item_t)) out_ch (clk);

  sliding_window_event_rate_monitor dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rate_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit [63:0] now = 0;
  bit [31:0] watched_id;

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_item(logic cmd, logic [31:0] src, logic flag, logic [63:0] t);
    in_item_t it;
    it.cmd = cmd;
    it.source_id = src;
    it.high_flag = flag;
    it.stamp = t;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
  endtask

  // Drop valid and hold until every outstanding result has arrived.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic run_random(int unsigned n);
    bit [63:0] base;
    bit [63:0] gap;
    bit [31:0] src;
    int unsigned r;
    base = sb.window / sb.threshold;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        // aim ticks at the scheduled check instant, or just short of it
        if (sb.deadline != 0 && sb.deadline > now && $urandom_range(1))
          now = sb.deadline - $urandom_range(1);
        else
          now = now + $urandom_range(0, 32'(base));
        if (now < sb.deadline - 64'd1 && sb.deadline - now < 2) now = sb.deadline;
        push_item(CMD_TICK, $urandom(), $urandom_range(1), now);
      end else begin
        r = $urandom_range(99);
        if (r < 70) gap = $urandom_range(0, 32'(2 * base));
        else if (r < 90) gap = base * $urandom_range(2, 8);
        else gap = sb.window + $urandom_range(0, 32'(sb.window));
        now = now + gap;
        src = ($urandom_range(99) < 88) ? watched_id : $urandom();
        push_item(CMD_EVENT, src, $urandom_range(1), now);
      end
    end
  endtask

  initial begin
    bit [63:0] dl;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    watched_id = $urandom() | 32'h1;

    // id zero and stamp zero before any lock, then lock and flag re-arm
    push_item(CMD_EVENT, 32'h0, 1'b0, 64'd0);
    push_item(CMD_TICK, 32'hFFFF_FFFF, 1'b1, 64'd0);
    push_item(CMD_EVENT, 32'h0, 1'b1, 64'd5);
    push_item(CMD_EVENT, watched_id, 1'b1, 64'd10);
    push_item(CMD_EVENT, watched_id, 1'b1, 64'd20);
    push_item(CMD_EVENT, watched_id, 1'b0, 64'd30);
    push_item(CMD_EVENT, watched_id, 1'b1, 64'd40);
    push_item(CMD_EVENT, ~watched_id, 1'b1, 64'd50);
    dl = sb.deadline;
    push_item(CMD_TICK, 32'h0, 1'b0, dl - 64'd1);
    push_item(CMD_TICK, 32'h0, 1'b0, dl);
    push_item(CMD_TICK, 32'h0, 1'b0, dl + 64'd100);
    push_item(CMD_EVENT, watched_id, 1'b0, dl + 64'd200);
    now = dl + 64'd200;
    drain();

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 22 : (m == 1) ? 84 : 0;
      recv_idle_pct = (m == 0) ? 84 : (m == 1) ? 22 : 0;
      write_reg(CFG_LOW_THRESHOLD, 4);
      write_reg(CFG_WINDOW_LENGTH, 1000000);
      run_random(100);
      drain();
      write_reg(CFG_LOW_THRESHOLD, 1);
      write_reg(CFG_WINDOW_LENGTH, 1000000 + $urandom_range(0, 500000));
      run_random(100);
      drain();
      write_reg(CFG_LOW_THRESHOLD, 40);
      write_reg(CFG_WINDOW_LENGTH, 3000000);
      run_random(100);
      drain();
    end

    // widest settings: a short burst, a due check, then let it all expire
    write_reg(CFG_LOW_THRESHOLD, 16384);
    write_reg(CFG_WINDOW_LENGTH, 34'd10000000000);
    for (int i = 0; i < 16; i++) begin
      now = now + 64'd1000;
      push_item(CMD_EVENT, watched_id, i[0], now);
    end
    if (sb.deadline > now) now = sb.deadline;
    push_item(CMD_TICK, 32'h0, 1'b0, now);
    now = now + 64'd20000000000;
    push_item(CMD_EVENT, watched_id, 1'b0, now);
    drain();

    // top of the time range, where deadlines wrap
    write_reg(CFG_LOW_THRESHOLD, 1);
    write_reg(CFG_WINDOW_LENGTH, 1000000);
    push_item(CMD_EVENT, watched_id, 1'b1, 64'hFFFF_FFFF_FFD2_39FF);
    push_item(CMD_EVENT, watched_id, 1'b0, 64'hFFFF_FFFF_FFF0_BDBF);
    push_item(CMD_TICK, 32'h0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE);
    push_item(CMD_EVENT, watched_id, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(CMD_TICK, 32'h0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
